// ===== hw/rtl/scfl_pkg.sv =====
// Shared types and constants of the supply compensated fan level block.
// Holds the beat payload structs, the controller/datapath command and status
// structs and the fixed arithmetic constants. Depends on nothing.
package scfl_pkg;

    localparam int CAL_W = 20;
    localparam int DIG_W = 14;

    localparam logic [CAL_W-1:0] CAL_RESET  = 20'd600;
    localparam logic [CAL_W-1:0] CAL_MAX    = 20'hFFFFF;
    localparam logic [9:0]       SUPPLY_REF = 10'd720;
    localparam logic [7:0]       WINDOW     = 8'd200;
    localparam logic [6:0]       LEVEL_MAX  = 7'd127;
    localparam logic [3:0]       DIGIT_NINE = 4'd9;

    localparam logic [1:0] MODE_SUPPLY = 2'd0;
    localparam logic [1:0] MODE_TEMP   = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;
    localparam logic [1:0] MODE_CAL    = 2'd3;

    localparam logic [1:0] DIG_THOUSANDS = 2'd0;
    localparam logic [1:0] DIG_HUNDREDS  = 2'd1;
    localparam logic [1:0] DIG_TENS      = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [9:0] sample;
    } item_t;

    typedef struct packed {
        logic [3:0] volts_tens;
        logic [3:0] volts_units;
        logic [3:0] volts_tenths;
        logic [3:0] level_digit;
        logic       level_shown;
        logic [7:0] pwm_duty;
    } result_t;

    typedef struct packed {
        logic       latch_item;
        logic       update_avg;
        logic       mul;
        logic       div_start;
        logic       apply;
        logic       u_load;
        logic       dig_step;
        logic [1:0] dig_idx;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       volt_zero;
        logic       div_busy;
    } status_t;

    // Decimal weight of the digit produced at each conversion step.
    function automatic logic [9:0] place_value(input logic [1:0] idx);
        logic [9:0] p;
        case (idx)
            DIG_THOUSANDS: p = 10'd1000;
            DIG_HUNDREDS:  p = 10'd100;
            DIG_TENS:      p = 10'd10;
            default:       p = 10'd1;
        endcase
        return p;
    endfunction

endpackage

// ===== hw/rtl/scfl_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Used by the datapath for both the start value and calibration quotients.
// Depends on nothing.
module scfl_div #(
    parameter int N     = 30,
    parameter int DVS_W = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [N-1:0]     dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [N-1:0]     quotient
);

    localparam int CNT_W = $clog2(N + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [N-1:0]     quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;
    assign shifted  = {rem_reg, quo_reg[N-1]};
    assign ge       = (shifted >= {1'b0, divisor});
    assign diff     = shifted - {1'b0, divisor};

    always_comb
    begin
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (start)
        begin
            cnt_next = CNT_W'(N);
            quo_next = dividend;
            rem_next = '0;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 1'b1;
            quo_next = {quo_reg[N-2:0], ge};
            rem_next = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

endmodule

// ===== hw/rtl/scfl_dp.sv =====
// Datapath: averages, calibration, fan level, multiplier, digit conversion
// and the result register. Depends on scfl_pkg and scfl_div.
module scfl_dp #(
    parameter int ADC_BITS = 10
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  scfl_pkg::item_t                        item,
    input  scfl_pkg::cmd_t                         cmd,
    input  logic                                   cfg_we,
    input  logic [scfl_pkg::CAL_W-1:0]             cfg_data,
    output scfl_pkg::status_t                      status,
    output scfl_pkg::result_t                      result
);

    localparam int SX_W  = (ADC_BITS > 10) ? ADC_BITS : 10;
    localparam int DVS_W = (ADC_BITS > 10) ? ADC_BITS : 10;
    localparam int N     = scfl_pkg::CAL_W + ADC_BITS;
    localparam int CW    = scfl_pkg::CAL_W;
    localparam int DW    = scfl_pkg::DIG_W;

    logic [1:0]          mode_reg;
    logic [9:0]          sample_reg;
    logic [ADC_BITS-1:0] volt_reg, volt_next;
    logic [ADC_BITS-1:0] temp_reg, temp_next;
    logic [CW-1:0]       cal_reg, cal_next;
    logic [6:0]          lvl_reg, lvl_next;
    logic [N-1:0]        prod_reg;
    logic [DW-1:0]       rem_reg, rem_next;
    logic [3:0]          d2_reg, d1_reg, d0_reg;
    logic [3:0]          d2_next, d1_next, d0_next;
    scfl_pkg::result_t   result_reg, result_next;

    logic [SX_W-1:0]     s_wide;
    logic [ADC_BITS-1:0] s_adc;
    logic                is_tick;
    logic [CW-1:0]       mul_a;
    logic [ADC_BITS-1:0] mul_b;
    logic [N-1:0]        prod_mul;
    logic [DVS_W-1:0]    divisor;
    logic                div_busy;
    logic [N-1:0]        quotient;
    logic [N-1:0]        temp_ext;
    logic [N-1:0]        delta;
    logic                in_window;
    logic [7:0]          delta8;
    logic [7:0]          lvl_ext;
    logic [6:0]          lvl_tick;
    logic [CW-1:0]       cal_sat;
    logic [DW-1:0]       u_val;
    logic [DW-1:0]       place;
    logic [3:0]          dig;
    logic [DW-1:0]       sub;

    // Leaky average: avg + floor((s - avg) / 2^sh).
    function automatic logic [ADC_BITS-1:0] leaky(
        input logic [ADC_BITS-1:0] avg,
        input logic [ADC_BITS-1:0] s,
        input int unsigned         sh
    );
        logic signed [ADC_BITS:0] d;
        logic signed [ADC_BITS:0] stp;
        logic signed [ADC_BITS:0] sum;
        d   = $signed({1'b0, s}) - $signed({1'b0, avg});
        stp = d >>> sh;
        sum = $signed({1'b0, avg}) + stp;
        return sum[ADC_BITS-1:0];
    endfunction

    assign s_wide  = SX_W'(sample_reg);
    assign s_adc   = s_wide[ADC_BITS-1:0];
    assign is_tick = (mode_reg == scfl_pkg::MODE_TICK);

    // Tick: cal * volt / 720. Calibrate: temp * 720 / volt.
    assign mul_a    = is_tick ? cal_reg : CW'(scfl_pkg::SUPPLY_REF);
    assign mul_b    = is_tick ? volt_reg : temp_reg;
    assign prod_mul = {{ADC_BITS{1'b0}}, mul_a} * {{CW{1'b0}}, mul_b};
    assign divisor  = is_tick ? DVS_W'(scfl_pkg::SUPPLY_REF) : DVS_W'(volt_reg);

    scfl_div #(
        .N     (N),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // Fan level step: delta is start - temp, valid inside the window.
    assign temp_ext  = N'(temp_reg);
    assign delta     = quotient - temp_ext;
    assign in_window = (quotient > temp_ext) && (delta < N'(scfl_pkg::WINDOW));
    assign delta8    = delta[7:0];
    assign lvl_ext   = {1'b0, lvl_reg};

    always_comb
    begin
        lvl_tick = lvl_reg;
        if (!in_window)
        begin
            lvl_tick = '0;
        end
        else if (delta8 > lvl_ext + 8'd1)
        begin
            if (lvl_reg != scfl_pkg::LEVEL_MAX)
            begin
                lvl_tick = lvl_reg + 7'd1;
            end
        end
        else if (delta8 + 8'd1 < lvl_ext)
        begin
            lvl_tick = lvl_reg - 7'd1;
        end
    end

    assign cal_sat = (|quotient[N-1:CW]) ? scfl_pkg::CAL_MAX : quotient[CW-1:0];

    // Supply reading in hundredths of a volt.
    assign u_val = (DW'(volt_reg) << 1) - DW'(volt_reg >> 5) - DW'(volt_reg >> 6);

    // One decimal digit per step: count how many multiples of the place fit.
    assign place = DW'(scfl_pkg::place_value(cmd.dig_idx));

    always_comb
    begin
        dig = '0;
        sub = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (rem_reg >= DW'(k) * place)
            begin
                dig = 4'(k);
                sub = DW'(k) * place;
            end
        end
    end

    always_comb
    begin
        volt_next = volt_reg;
        temp_next = temp_reg;
        cal_next  = cal_reg;
        lvl_next  = lvl_reg;
        rem_next  = rem_reg;
        d2_next   = d2_reg;
        d1_next   = d1_reg;
        d0_next   = d0_reg;
        if (cmd.update_avg && mode_reg == scfl_pkg::MODE_SUPPLY)
        begin
            volt_next = leaky(volt_reg, s_adc, 2);
        end
        if (cmd.update_avg && mode_reg == scfl_pkg::MODE_TEMP)
        begin
            temp_next = leaky(temp_reg, s_adc, 3);
        end
        if (cmd.apply && is_tick)
        begin
            lvl_next = lvl_tick;
        end
        if (cfg_we)
        begin
            cal_next = cfg_data;
        end
        else if (cmd.apply && mode_reg == scfl_pkg::MODE_CAL)
        begin
            cal_next = cal_sat;
        end
        if (cmd.u_load)
        begin
            rem_next = u_val;
        end
        else if (cmd.dig_step)
        begin
            rem_next = rem_reg - sub;
            case (cmd.dig_idx)
                scfl_pkg::DIG_THOUSANDS: d2_next = dig;
                scfl_pkg::DIG_HUNDREDS:  d1_next = dig;
                default:                 d0_next = dig;
            endcase
        end
    end

    // Result: tenths rounded from the leftover hundredths, with carry.
    always_comb
    begin
        logic [3:0] r2;
        logic [3:0] r1;
        logic [3:0] r0;
        r2 = d2_reg;
        r1 = d1_reg;
        r0 = d0_reg;
        if (rem_reg > DW'(4))
        begin
            if (d0_reg != scfl_pkg::DIGIT_NINE)
            begin
                r0 = d0_reg + 4'd1;
            end
            else
            begin
                r0 = '0;
                if (d1_reg != scfl_pkg::DIGIT_NINE)
                begin
                    r1 = d1_reg + 4'd1;
                end
                else
                begin
                    r1 = '0;
                    r2 = d2_reg + 4'd1;
                end
            end
        end
        result_next              = result_reg;
        result_next.volts_tens   = r2;
        result_next.volts_units  = r1;
        result_next.volts_tenths = r0;
        result_next.level_digit  = lvl_reg[6:3];
        result_next.level_shown  = |lvl_reg[6:3];
        result_next.pwm_duty     = {lvl_reg, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_reg <= '0;
            temp_reg <= '0;
            cal_reg  <= scfl_pkg::CAL_RESET;
            lvl_reg  <= '0;
        end
        else
        begin
            volt_reg <= volt_next;
            temp_reg <= temp_next;
            cal_reg  <= cal_next;
            lvl_reg  <= lvl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            mode_reg   <= item.mode;
            sample_reg <= item.sample;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_mul;
        end
        if (cmd.out_load)
        begin
            result_reg <= result_next;
        end
        rem_reg <= rem_next;
        d2_reg  <= d2_next;
        d1_reg  <= d1_next;
        d0_reg  <= d0_next;
    end

    assign status.mode      = mode_reg;
    assign status.volt_zero = (volt_reg == '0);
    assign status.div_busy  = div_busy;
    assign result           = result_reg;

endmodule

// ===== hw/rtl/scfl_ctrl.sv =====
// Controller state machine: sequences one item through the datapath and
// owns both handshakes. Depends on scfl_pkg.
module scfl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    output logic              result_valid,
    input  logic              result_ready,
    input  scfl_pkg::status_t status,
    output scfl_pkg::cmd_t    cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_DIVS  = 4'd3;
    localparam logic [3:0] S_DIVW  = 4'd4;
    localparam logic [3:0] S_APPLY = 4'd5;
    localparam logic [3:0] S_ULOAD = 4'd6;
    localparam logic [3:0] S_DIG   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        cmd        = '0;
        cmd.dig_idx = idx_reg;
        if (valid_reg && result_ready)
        begin
            valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = S_DISP;
                end
            end
            S_DISP:
            begin
                case (status.mode)
                    scfl_pkg::MODE_SUPPLY, scfl_pkg::MODE_TEMP:
                    begin
                        cmd.update_avg = 1'b1;
                        state_next     = S_ULOAD;
                    end
                    scfl_pkg::MODE_TICK:
                    begin
                        state_next = S_MUL;
                    end
                    default:
                    begin
                        state_next = status.volt_zero ? S_ULOAD : S_MUL;
                    end
                endcase
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVW;
            end
            S_DIVW:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = S_ULOAD;
            end
            S_ULOAD:
            begin
                cmd.u_load = 1'b1;
                idx_next   = scfl_pkg::DIG_THOUSANDS;
                state_next = S_DIG;
            end
            S_DIG:
            begin
                cmd.dig_step = 1'b1;
                idx_next     = idx_reg + 2'd1;
                if (idx_reg == scfl_pkg::DIG_TENS)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!valid_reg || result_ready)
                begin
                    cmd.out_load = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== hw/rtl/supply_compensated_fan_level.sv =====
// Supply compensated fan level: one result beat for every item beat.
// Samples and a calibrate on zero supply go straight from dispatch to the decimal conversion;
// ticks and other calibrates first pass through the multiplier and the shared restoring
// divider, which retires one quotient bit per cycle.
// One item is in work at a time; a new item can be taken in the same cycle as the result of
// the previous one goes valid. Reset is asynchronous, active low.
module supply_compensated_fan_level #(
    parameter int ADC_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  scfl_pkg::item_t               item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output scfl_pkg::result_t             result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [scfl_pkg::CAL_W-1:0]    cfg_data
);

    scfl_pkg::cmd_t    cmd;
    scfl_pkg::status_t status;

    // Configuration beats must only be sent while the block is idle; the block
    // itself does not enforce this, and cfg_ready is tied high.
    assign cfg_ready = 1'b1;

    // The controller accepts an item in its idle state and walks it through
    // the datapath: supply and temperature samples update their leaky
    // average; a tick multiplies the calibration value by the supply average
    // and divides by 720 to get the start temperature, then steps the fan
    // level; a calibrate command computes temp * 720 / volt, kept unchanged
    // when the supply average is zero. Every item ends with a three step
    // decimal conversion of the supply reading and a load of the result.
    // The result register lets the next item start while the previous result
    // waits; the item input is not ready while an item is in work, and also stalls
    // when a second result is ready before the first one has been taken.
    scfl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    // The datapath holds all block state, the multiplier, the divider and
    // the registered result.
    scfl_dp #(
        .ADC_BITS (ADC_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cmd      (cmd),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .status   (status),
        .result   (result)
    );

endmodule
